### hdl/cidr_acl_pkg.sv
// Shared types, constants and helpers for the IPv4 CIDR ACL match unit.
`default_nettype none
package cidr_acl_pkg;

  localparam int TableDepth = 16;
  localparam int AddrBits   = 32;
  localparam int LenBits    = 6;

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_MATCHED    = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_FULL       = 3'd3,
    ST_BAD_LENGTH = 3'd4
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [AddrBits-1:0]  address;
    logic [LenBits-1:0]   prefix_length;
  } req_t;

  typedef struct packed {
    logic    matched;
    status_t status;
  } rsp_t;

  // request as it travels down the chain of cells
  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [AddrBits-1:0] address;
    logic [LenBits-1:0]  prefix_length;
    logic                bad;   // length above AddrBits, set for any request; only an add acts on it
    logic                done;  // add: stored; query: hit
  } stage_t;

  function automatic logic [AddrBits-1:0] prefix_mask(input logic [LenBits-1:0] len);
    logic [AddrBits-1:0] mask;
    if (len >= LenBits'(AddrBits)) begin
      mask = '1;
    end else begin
      mask = ~({AddrBits{1'b1}} >> len);
    end
    return mask;
  endfunction

endpackage
`default_nettype wire

### hdl/cidr_acl_cell.sv
// One rule slot of the ACL chain: stores a rule or tests a query, then passes the request on.
`default_nettype none
module cidr_acl_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire cidr_acl_pkg::stage_t stage_in,
  output cidr_acl_pkg::stage_t      stage_out,
  output logic                      occupied
);
  import cidr_acl_pkg::*;

  logic [AddrBits-1:0] rule_prefix;
  logic [LenBits-1:0]  rule_length;
  logic                store;
  logic                hit;
  stage_t              stage_next;

  always_comb begin
    store = stage_in.valid && (stage_in.kind == KIND_ADD) && !stage_in.bad &&
            !stage_in.done && !occupied;
    hit   = stage_in.valid && (stage_in.kind == KIND_QUERY) && occupied &&
            (((stage_in.address ^ rule_prefix) & prefix_mask(rule_length)) == '0);
    stage_next      = stage_in;
    stage_next.done = stage_in.done || store || hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied        <= 1'b0;
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out.valid <= stage_next.valid;
      if (store) begin
        occupied <= 1'b1;
      end
    end
    if (advance) begin
      stage_out.kind          <= stage_next.kind;
      stage_out.address       <= stage_next.address;
      stage_out.prefix_length <= stage_next.prefix_length;
      stage_out.bad           <= stage_next.bad;
      stage_out.done          <= stage_next.done;
      if (store) begin
        rule_prefix <= stage_in.address & prefix_mask(stage_in.prefix_length);
        rule_length <= stage_in.prefix_length;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/ipv4_cidr_acl_match_unit.sv
// Top level of the IPv4 CIDR ACL match unit: input stage, chain of rule cells, result register.
//
//  channel | direction | payload | handshake
//  --------+-----------+---------+----------------------
//  request | in        | req_t   | req_valid / req_ready
//  result  | out       | rsp_t   | rsp_valid / rsp_ready
//
// One request enters per cycle while no held result stalls the chain; the first cell captures
// it at the accepting edge, and it passes every rule cell and the result register to rsp_valid.
// Adds fill the first empty cell they pass, so later queries always see them.
// Reset empties every cell (one occupied flag per cell, cleared at once).
// A held result stalls the whole chain; req_ready drops until it is taken.
`default_nettype none
module ipv4_cidr_acl_match_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire cidr_acl_pkg::req_t req_data,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output cidr_acl_pkg::rsp_t      rsp_data
);
  import cidr_acl_pkg::*;

  stage_t                links [TableDepth+1];
  logic [TableDepth-1:0] occupied;
  logic                  advance;
  rsp_t                  rsp_next;
  stage_t                last;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = advance;

  always_comb begin
    links[0].valid         = req_valid;
    links[0].kind          = req_data.kind;
    links[0].address       = req_data.address;
    links[0].prefix_length = req_data.prefix_length;
    links[0].bad           = req_data.prefix_length > LenBits'(AddrBits);
    links[0].done          = 1'b0;
  end

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    cidr_acl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .stage_in  (links[i]),
      .stage_out (links[i+1]),
      .occupied  (occupied[i])
    );
  end

  assign last = links[TableDepth];

  always_comb begin
    rsp_next.matched = 1'b0;
    unique case (last.kind)
      KIND_ADD: begin
        if (last.bad) begin
          rsp_next.status = ST_BAD_LENGTH;
        end else if (last.done) begin
          rsp_next.status = ST_ADDED;
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      KIND_QUERY: begin
        rsp_next.matched = last.done;
        rsp_next.status  = last.done ? ST_MATCHED : ST_NOT_FOUND;
      end
      default: begin
        rsp_next.status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // cells fill from the head of the chain with no gaps
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    (occupied & (occupied + TableDepth'(1))) == '0)
    else $error("rule cells filled out of order");

  // the table never shrinks and grows by at most one rule per cycle
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(occupied) >= $countones($past(occupied))) &&
                    ($countones(occupied) <= $countones($past(occupied)) + 1))
    else $error("rule count changed by more than one");

  // a cell is only taken while the chain moves
  a_fill_on_advance: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(advance) |-> occupied == $past(occupied))
    else $error("rule stored during a stall");

  // matched is set exactly for a hit
  a_matched_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.matched == (rsp_data.status == ST_MATCHED)))
    else $error("matched flag disagrees with status");
`endif

endmodule
`default_nettype wire

### test/acl_match_checker.sv
// Checker for the IPv4 CIDR ACL match unit: keeps its own rule table and compares every result.
`timescale 1ns / 1ps
module acl_match_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  cidr_acl_pkg::req_t req_data,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  cidr_acl_pkg::rsp_t rsp_data,
  output int unsigned        mismatches,
  output int unsigned        outstanding
);
  import cidr_acl_pkg::*;

  localparam int MaxPrinted = 100;
  localparam int IdxBits    = $clog2(TableDepth);

  logic [AddrBits-1:0] net_base [TableDepth];
  logic [LenBits-1:0]  net_len  [TableDepth];
  int unsigned         net_count;
  rsp_t                acl_results_due [$];
  rsp_t                due;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    net_count   = 0;
  end

  function automatic logic [AddrBits-1:0] net_mask(input logic [LenBits-1:0] len);
    if (len == '0) return '0;
    return {AddrBits{1'b1}} << (AddrBits - int'(len));
  endfunction

  // Applies one request to the local table and returns the result it must produce.
  function automatic rsp_t acl_outcome(input req_t r);
    rsp_t o;
    o.matched = 1'b0;
    if (r.kind == KIND_ADD) begin
      // length check wins over the full check
      if (r.prefix_length > LenBits'(AddrBits)) begin
        o.status = ST_BAD_LENGTH;
      end else if (net_count >= TableDepth) begin
        o.status = ST_FULL;
      end else begin
        net_base[net_count[IdxBits-1:0]] = r.address & net_mask(r.prefix_length);
        net_len[net_count[IdxBits-1:0]]  = r.prefix_length;
        net_count++;
        o.status = ST_ADDED;
      end
    end else begin
      o.status = ST_NOT_FOUND;
      for (int i = 0; i < net_count; i++) begin
        if (((r.address ^ net_base[i[IdxBits-1:0]]) & net_mask(net_len[i[IdxBits-1:0]]))
            == '0) begin
          o.matched = 1'b1;
          o.status  = ST_MATCHED;
        end
      end
    end
    return o;
  endfunction

  // printing stops after a while so a broken block cannot flood the log
  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      net_count = 0;
      acl_results_due.delete();
      outstanding <= 0;
    end else begin
      if (req_valid && req_ready) acl_results_due.push_back(acl_outcome(req_data));
      if (rsp_valid && rsp_ready) begin
        if (acl_results_due.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: %p", rsp_data));
        end else begin
          due = acl_results_due.pop_front();
          if (rsp_data.matched !== due.matched)
            report_mismatch($sformatf("matched %b, want %b", rsp_data.matched, due.matched));
          if (rsp_data.status !== due.status)
            report_mismatch($sformatf("status %0d, want %s", rsp_data.status, due.status.name()));
        end
      end
      outstanding <= acl_results_due.size();
    end
  end

endmodule

### test/tb_top.sv
// Testbench top for the IPv4 CIDR ACL match unit: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps
module tb_top;
  import cidr_acl_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int Phases      = 4;
  localparam int PerPhase    = 282;
  localparam int LimitCycles = 400_000;
  localparam int IdxBits     = $clog2(TableDepth);
  localparam int BitIdx      = $clog2(AddrBits);

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req_data  = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp_data;
  int unsigned mismatches;
  int unsigned outstanding;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // what the stimulus has stored so far, used to aim queries at live rules
  logic [AddrBits-1:0] sent_base [TableDepth];
  logic [LenBits-1:0]  sent_len  [TableDepth];
  int unsigned         stored_rules = 0;
  int unsigned         add_count    = 0;
  int unsigned         bad_count    = 0;
  int unsigned         query_count  = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  ipv4_cidr_acl_match_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  acl_match_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic req_t acl_req(input kind_t k, input logic [AddrBits-1:0] a,
                                   input logic [LenBits-1:0] l);
    req_t r;
    r.kind          = k;
    r.address       = a;
    r.prefix_length = l;
    return r;
  endfunction

  function automatic req_t random_acl_req(input bit allow_store);
    req_t                r;
    int unsigned         pick;
    int unsigned         k;
    int unsigned         flip;
    logic [AddrBits-1:0] low;
    pick            = $urandom_range(0, 99);
    r.kind          = KIND_QUERY;
    r.address       = $urandom();
    r.prefix_length = LenBits'($urandom_range(0, 63));
    if (pick < 5) begin
      r.kind          = KIND_ADD;
      r.prefix_length = LenBits'($urandom_range(AddrBits + 1, 63));
    end else if (pick < 7 && allow_store) begin
      r.kind = KIND_ADD;
      if ($urandom_range(0, 3) == 0) r.prefix_length = LenBits'($urandom_range(1, AddrBits));
      else r.prefix_length = LenBits'($urandom_range(12, AddrBits));
    end else if (pick < 60 && stored_rules > 0) begin
      // land inside a stored network, then sometimes knock one prefix bit off it
      k         = $urandom_range(0, stored_rules - 1);
      low       = {AddrBits{1'b1}} >> sent_len[k[IdxBits-1:0]];
      r.address = (sent_base[k[IdxBits-1:0]] & ~low) | (r.address & low);
      if (pick >= 40 && sent_len[k[IdxBits-1:0]] != 0) begin
        flip = AddrBits - 1 - $urandom_range(0, int'(sent_len[k[IdxBits-1:0]]) - 1);
        r.address[flip[BitIdx-1:0]] = ~r.address[flip[BitIdx-1:0]];
      end
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    if (r.kind == KIND_QUERY) begin
      query_count++;
    end else begin
      add_count++;
      if (r.prefix_length > LenBits'(AddrBits)) begin
        bad_count++;
      end else if (stored_rules < TableDepth) begin
        sent_base[stored_rules[IdxBits-1:0]] = r.address;
        sent_len[stored_rules[IdxBits-1:0]]  = r.prefix_length;
        stored_rules++;
      end
    end
  endtask

  task automatic wait_results_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table, bad lengths, then a handful of rules probed at their edges
    send_req(acl_req(KIND_QUERY, 32'h0000_0000, 6'd0));
    send_req(acl_req(KIND_QUERY, 32'hFFFF_FFFF, 6'h3F));
    send_req(acl_req(KIND_ADD,   32'h0A00_0000, 6'd33));
    send_req(acl_req(KIND_ADD,   32'hFFFF_FFFF, 6'd63));
    send_req(acl_req(KIND_ADD,   32'hFFFF_FFFF, 6'd32));
    send_req(acl_req(KIND_QUERY, 32'hFFFF_FFFF, 6'd0));
    send_req(acl_req(KIND_QUERY, 32'hFFFF_FFFE, 6'd32));
    send_req(acl_req(KIND_ADD,   32'h0A12_3456, 6'd8));
    send_req(acl_req(KIND_QUERY, 32'h0AFF_FFFF, 6'd0));
    send_req(acl_req(KIND_QUERY, 32'h0B00_0000, 6'd8));
    send_req(acl_req(KIND_ADD,   32'hC0A8_01FF, 6'd24));
    send_req(acl_req(KIND_QUERY, 32'hC0A8_0100, 6'h2A));
    send_req(acl_req(KIND_QUERY, 32'hC0A8_0200, 6'h15));
    send_req(acl_req(KIND_ADD,   32'h0000_0001, 6'd31));
    send_req(acl_req(KIND_QUERY, 32'h0000_0000, 6'd0));
    send_req(acl_req(KIND_QUERY, 32'h0000_0002, 6'd0));
    send_req(acl_req(KIND_ADD,   32'h1234_5678, 6'd16));
    send_req(acl_req(KIND_QUERY, 32'h1234_0000, 6'd0));
    send_req(acl_req(KIND_QUERY, 32'h1235_FFFF, 6'd0));
    send_req(acl_req(KIND_QUERY, 32'h7FFF_FFFF, 6'h3F));

    for (int p = 0; p < Phases; p++) begin
      wait_results_drained();
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      // last phase: fill to one short of full, later the catch-all rule takes the last slot
      if (p == Phases - 1) begin
        while (stored_rules < TableDepth - 1)
          send_req(acl_req(KIND_ADD, $urandom(), LenBits'($urandom_range(8, AddrBits))));
      end
      for (int n = 0; n < PerPhase; n++) begin
        if (p == Phases - 1 && n == PerPhase / 2)
          send_req(acl_req(KIND_ADD, $urandom(), 6'd0));
        send_req(random_acl_req(stored_rules < TableDepth - 1 || stored_rules == TableDepth));
      end
    end

    wait_results_drained();
    repeat (TableDepth + 4) @(posedge clk);

    $display("Summary: %0d requests, %0d queries and %0d adds (%0d with bad length), %0d rules held",
             query_count + add_count, query_count, add_count, bad_count, stored_rules);
    $display("Summary: traffic ran free, with 76%% sender gaps, 76%% receiver stalls, 16%% of both");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(ClkPeriod * LimitCycles);
    $display("TB_ERROR");
    $finish;
  end

endmodule
